@@ src/sxt_pkg.sv @@
// Shared types and constants for the s-expression tokenizer.
// Used by every module of the block; depends on nothing.
package sxt_pkg;

  localparam int OFFSET_WIDTH_DEF = 24;
  localparam int LINE_WIDTH_DEF   = 20;
  localparam int COLUMN_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int OUT_OFFSET_W = 24;
  localparam int OUT_LINE_W   = 20;
  localparam int OUT_COLUMN_W = 16;

  localparam logic [3:0] KIND_OPEN   = 4'd0;
  localparam logic [3:0] KIND_CLOSE  = 4'd1;
  localparam logic [3:0] KIND_QUOTE  = 4'd2;
  localparam logic [3:0] KIND_IDENT  = 4'd3;
  localparam logic [3:0] KIND_STRING = 4'd4;
  localparam logic [3:0] KIND_NUMBER = 4'd5;
  localparam logic [3:0] KIND_TRUE   = 4'd6;
  localparam logic [3:0] KIND_FALSE  = 4'd7;
  localparam logic [3:0] KIND_ERROR  = 4'd8;
  localparam logic [3:0] KIND_END    = 4'd9;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_APOSTR    = 8'h27;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_OPEN      = 8'h28;
  localparam logic [7:0] CH_CLOSE     = 8'h29;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]               token_kind;
    logic [OUT_OFFSET_W-1:0]  start_offset;
    logic [OUT_OFFSET_W-1:0]  token_length;
    logic [OUT_LINE_W-1:0]    start_line;
    logic [OUT_COLUMN_W-1:0]  start_column;
    logic signed [31:0]       number_value;
    logic                     last_of_run;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd0) || (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

@@ src/sxt_front.sv @@
// Scanner: accepts source bytes, tracks positions and scan mode, builds tokens.
// Depends on sxt_pkg; writes at most one record, of up to two tokens, per item.
module sxt_front #(
  parameter int OFFSET_WIDTH = sxt_pkg::OFFSET_WIDTH_DEF,
  parameter int LINE_WIDTH   = sxt_pkg::LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = sxt_pkg::COLUMN_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  sxt_pkg::in_item_t in_data,
  output logic              rec_push,
  output sxt_pkg::rec_t     rec_data
);

  localparam int OW = OFFSET_WIDTH;
  localparam int LW = LINE_WIDTH;
  localparam int CW = COLUMN_WIDTH;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_COMMENT = 8'b0000_0010,
    M_HASH    = 8'b0000_0100,
    M_STRING  = 8'b0000_1000,
    M_ESCAPE  = 8'b0001_0000,
    M_NUMBER  = 8'b0010_0000,
    M_IDENT   = 8'b0100_0000,
    M_HALT    = 8'b1000_0000
  } mode_t;

  mode_t         mode_r, mode_nxt;
  logic [OW-1:0] cur_off_r, cur_off_nxt, st_off_r, st_off_nxt;
  logic [LW-1:0] cur_line_r, cur_line_nxt, st_line_r, st_line_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt, st_col_r, st_col_nxt;
  logic [31:0]   acc_r, acc_nxt;

  logic [7:0]    c;
  logic          eoi;
  logic [OW-1:0] a_off;
  logic [LW-1:0] a_line;
  logic [CW-1:0] a_col;
  logic [31:0]   acc_step;
  logic          pre_v, idl_v, do_idle;
  sxt_pkg::token_t pre_t, idl_t;

  function automatic logic [OW-1:0] span(input logic [OW-1:0] a, input logic [OW-1:0] b);
    return (a >= b) ? a - b : '0;
  endfunction

  function automatic sxt_pkg::token_t make_tok(
    input logic [3:0]    kind,
    input logic [OW-1:0] so,
    input logic [OW-1:0] len,
    input logic [LW-1:0] sl,
    input logic [CW-1:0] sc,
    input logic [31:0]   val
  );
    sxt_pkg::token_t t;
    logic [OW+sxt_pkg::OUT_OFFSET_W-1:0] so_e, len_e;
    logic [LW+sxt_pkg::OUT_LINE_W-1:0]   sl_e;
    logic [CW+sxt_pkg::OUT_COLUMN_W-1:0] sc_e;
    so_e  = {{sxt_pkg::OUT_OFFSET_W{1'b0}}, so};
    len_e = {{sxt_pkg::OUT_OFFSET_W{1'b0}}, len};
    sl_e  = {{sxt_pkg::OUT_LINE_W{1'b0}}, sl};
    sc_e  = {{sxt_pkg::OUT_COLUMN_W{1'b0}}, sc};
    t.token_kind   = kind;
    t.start_offset = so_e[sxt_pkg::OUT_OFFSET_W-1:0];
    t.token_length = len_e[sxt_pkg::OUT_OFFSET_W-1:0];
    t.start_line   = sl_e[sxt_pkg::OUT_LINE_W-1:0];
    t.start_column = sc_e[sxt_pkg::OUT_COLUMN_W-1:0];
    t.number_value = val;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  assign c        = in_data.source_byte;
  assign eoi      = in_data.end_of_input;
  assign a_off    = (cur_off_r == '1) ? cur_off_r : cur_off_r + 1'b1;
  assign a_line   = (c != sxt_pkg::CH_NEWLINE) ? cur_line_r :
                    ((cur_line_r == '1) ? cur_line_r : cur_line_r + 1'b1);
  assign a_col    = (c == sxt_pkg::CH_NEWLINE) ? CW'(1) :
                    ((cur_col_r == '1) ? cur_col_r : cur_col_r + 1'b1);
  assign acc_step = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + {28'd0, c[3:0]};

  always_comb begin
    mode_nxt     = mode_r;
    cur_off_nxt  = cur_off_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    st_off_nxt   = st_off_r;
    st_line_nxt  = st_line_r;
    st_col_nxt   = st_col_r;
    acc_nxt      = acc_r;
    pre_v        = 1'b0;
    pre_t        = '0;
    idl_v        = 1'b0;
    idl_t        = '0;
    do_idle      = 1'b0;
    if (mode_r == M_HALT) begin
      mode_nxt = M_HALT;
    end else if (eoi) begin
      if (mode_r == M_HASH) begin
        pre_v    = 1'b1;
        pre_t    = make_tok(sxt_pkg::KIND_ERROR, st_off_r, OW'(1), st_line_r, st_col_r, '0);
        mode_nxt = M_HALT;
      end else begin
        if (mode_r == M_STRING || mode_r == M_ESCAPE) begin
          pre_v = 1'b1;
          pre_t = make_tok(sxt_pkg::KIND_STRING, st_off_r, span(cur_off_r, st_off_r),
                           st_line_r, st_col_r, '0);
        end else if (mode_r == M_NUMBER) begin
          pre_v = 1'b1;
          pre_t = make_tok(sxt_pkg::KIND_NUMBER, st_off_r, span(cur_off_r, st_off_r),
                           st_line_r, st_col_r, acc_r);
        end else if (mode_r == M_IDENT) begin
          pre_v = 1'b1;
          pre_t = make_tok(sxt_pkg::KIND_IDENT, st_off_r, span(cur_off_r, st_off_r),
                           st_line_r, st_col_r, '0);
        end
        st_off_nxt  = cur_off_r;
        st_line_nxt = cur_line_r;
        st_col_nxt  = cur_col_r;
        idl_v       = 1'b1;
        idl_t       = make_tok(sxt_pkg::KIND_END, cur_off_r, '0, cur_line_r, cur_col_r, '0);
        mode_nxt    = M_IDLE;
      end
    end else begin
      case (mode_r)
        M_COMMENT: begin
          cur_off_nxt  = a_off;
          cur_line_nxt = a_line;
          cur_col_nxt  = a_col;
          if (c == sxt_pkg::CH_NEWLINE) begin
            mode_nxt = M_IDLE;
          end
        end
        M_HASH: begin
          if (c == sxt_pkg::CH_LOWER_T || c == sxt_pkg::CH_LOWER_F) begin
            cur_off_nxt  = a_off;
            cur_line_nxt = a_line;
            cur_col_nxt  = a_col;
            pre_v        = 1'b1;
            pre_t        = make_tok((c == sxt_pkg::CH_LOWER_T) ? sxt_pkg::KIND_TRUE :
                                    sxt_pkg::KIND_FALSE, st_off_r, span(a_off, st_off_r),
                                    st_line_r, st_col_r, '0);
            mode_nxt     = M_IDLE;
          end else begin
            pre_v    = 1'b1;
            pre_t    = make_tok(sxt_pkg::KIND_ERROR, st_off_r, OW'(1), st_line_r, st_col_r, '0);
            mode_nxt = M_HALT;
          end
        end
        M_STRING: begin
          cur_off_nxt  = a_off;
          cur_line_nxt = a_line;
          cur_col_nxt  = a_col;
          if (c == sxt_pkg::CH_DQUOTE) begin
            pre_v    = 1'b1;
            pre_t    = make_tok(sxt_pkg::KIND_STRING, st_off_r, span(cur_off_r, st_off_r),
                                st_line_r, st_col_r, '0);
            mode_nxt = M_IDLE;
          end else if (c == sxt_pkg::CH_BACKSLASH) begin
            mode_nxt = M_ESCAPE;
          end
        end
        M_ESCAPE: begin
          cur_off_nxt  = a_off;
          cur_line_nxt = a_line;
          cur_col_nxt  = a_col;
          mode_nxt     = M_STRING;
        end
        M_NUMBER: begin
          if (sxt_pkg::is_digit(c)) begin
            acc_nxt      = acc_step;
            cur_off_nxt  = a_off;
            cur_line_nxt = a_line;
            cur_col_nxt  = a_col;
          end else begin
            pre_v   = 1'b1;
            pre_t   = make_tok(sxt_pkg::KIND_NUMBER, st_off_r, span(cur_off_r, st_off_r),
                               st_line_r, st_col_r, acc_r);
            do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (sxt_pkg::is_space(c) || c == sxt_pkg::CH_CLOSE) begin
            pre_v   = 1'b1;
            pre_t   = make_tok(sxt_pkg::KIND_IDENT, st_off_r, span(cur_off_r, st_off_r),
                               st_line_r, st_col_r, '0);
            do_idle = 1'b1;
          end else begin
            cur_off_nxt  = a_off;
            cur_line_nxt = a_line;
            cur_col_nxt  = a_col;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
      if (do_idle) begin
        mode_nxt     = M_IDLE;
        cur_off_nxt  = a_off;
        cur_line_nxt = a_line;
        cur_col_nxt  = a_col;
        if (sxt_pkg::is_space(c)) begin
          mode_nxt = M_IDLE;
        end else if (c == sxt_pkg::CH_SEMICOLON) begin
          mode_nxt = M_COMMENT;
        end else if (c == sxt_pkg::CH_APOSTR || c == sxt_pkg::CH_OPEN ||
                     c == sxt_pkg::CH_CLOSE) begin
          st_off_nxt  = cur_off_r;
          st_line_nxt = cur_line_r;
          st_col_nxt  = cur_col_r;
          idl_v       = 1'b1;
          idl_t       = make_tok((c == sxt_pkg::CH_APOSTR) ? sxt_pkg::KIND_QUOTE :
                                 ((c == sxt_pkg::CH_OPEN) ? sxt_pkg::KIND_OPEN :
                                  sxt_pkg::KIND_CLOSE), cur_off_r, span(a_off, cur_off_r),
                                 cur_line_r, cur_col_r, '0);
        end else if (c == sxt_pkg::CH_HASH) begin
          st_off_nxt  = cur_off_r;
          st_line_nxt = cur_line_r;
          st_col_nxt  = cur_col_r;
          mode_nxt    = M_HASH;
        end else if (c == sxt_pkg::CH_DQUOTE) begin
          st_off_nxt  = a_off;
          st_line_nxt = a_line;
          st_col_nxt  = a_col;
          mode_nxt    = M_STRING;
        end else if (sxt_pkg::is_digit(c)) begin
          st_off_nxt  = cur_off_r;
          st_line_nxt = cur_line_r;
          st_col_nxt  = cur_col_r;
          acc_nxt     = {28'd0, c[3:0]};
          mode_nxt    = M_NUMBER;
        end else begin
          st_off_nxt  = cur_off_r;
          st_line_nxt = cur_line_r;
          st_col_nxt  = cur_col_r;
          mode_nxt    = M_IDENT;
        end
      end
    end
  end

  always_comb begin
    rec_push                     = accept && (pre_v || idl_v);
    rec_data.two                 = pre_v && idl_v;
    rec_data.first               = pre_v ? pre_t : idl_t;
    rec_data.first.last_of_run   = !(pre_v && idl_v);
    rec_data.second              = idl_t;
    rec_data.second.last_of_run  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      cur_off_r  <= '0;
      cur_line_r <= LW'(1);
      cur_col_r  <= CW'(1);
      st_off_r   <= '0;
      st_line_r  <= LW'(1);
      st_col_r   <= CW'(1);
      acc_r      <= '0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      cur_off_r  <= cur_off_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      st_off_r   <= st_off_nxt;
      st_line_r  <= st_line_nxt;
      st_col_r   <= st_col_nxt;
      acc_r      <= acc_nxt;
    end
  end

endmodule

@@ src/sxt_queue.sv @@
// Short queue of token records between the scanner and the output stage.
// Depends on sxt_pkg for the record and status types.
module sxt_queue #(
  parameter int DEPTH = sxt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  sxt_pkg::rec_t     wr_data,
  input  logic              rd_en,
  output sxt_pkg::rec_t     rd_data,
  output sxt_pkg::q_stat_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  sxt_pkg::rec_t   mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_wr, do_rd;

  assign stat.full  = (count_r == CNTW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/sxt_back.sv @@
// Output stage: takes records from the queue and hands out one token per transfer.
// Depends on sxt_pkg for the record, token and status types.
module sxt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sxt_pkg::q_stat_t q_stat,
  input  sxt_pkg::rec_t    q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output sxt_pkg::token_t  out_data
);

  sxt_pkg::rec_t rec_r;
  logic          valid_r, valid_nxt;
  logic          sel_r, sel_nxt;
  logic          done;

  assign empty    = !valid_r;
  assign out_data = sel_r ? rec_r.second : rec_r.first;
  assign done     = valid_r && pop && (sel_r || !rec_r.two);
  assign q_pop    = !q_stat.empty && (!valid_r || done);

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    if (valid_r && pop && !sel_r && rec_r.two) begin
      sel_nxt = 1'b1;
    end else if (!valid_r || done) begin
      valid_nxt = !q_stat.empty;
      sel_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

@@ src/s_expression_tokenizer_top.sv @@
// Top level of the s-expression tokenizer: scanner, record queue and output stage.
// Depends on sxt_pkg, sxt_front, sxt_queue and sxt_back.
//
//   channel   ports                     transfer when
//   input     push, full, in_data       push high and full low
//   result    pop, empty, out_data      pop high and empty low
//
// The scanner takes one byte or end marker per cycle while the queue has room; its mode
// and position registers update on each accepted item, so items enter back to back.
// An item yields zero, one or two tokens; the output stage sends one token per cycle
// while pop is high and tokens wait, so items that yield two tokens take two transfers.
// Reset is synchronous and clears the scan state, the queue and the output stage.
// A stalled result side fills the queue and then holds full high.
module s_expression_tokenizer_top #(
  parameter int OFFSET_WIDTH = sxt_pkg::OFFSET_WIDTH_DEF,
  parameter int LINE_WIDTH   = sxt_pkg::LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = sxt_pkg::COLUMN_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = sxt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  sxt_pkg::in_item_t in_data,
  input  logic              pop,
  output logic              empty,
  output sxt_pkg::token_t   out_data
);

  logic             accept;
  logic             rec_push;
  sxt_pkg::rec_t    rec_wr, rec_rd;
  logic             q_pop;
  sxt_pkg::q_stat_t q_stat;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  sxt_front #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .LINE_WIDTH  (LINE_WIDTH),
    .COLUMN_WIDTH(COLUMN_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .rec_push(rec_push),
    .rec_data(rec_wr)
  );

  sxt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_push),
    .wr_data(rec_wr),
    .rd_en  (q_pop),
    .rd_data(rec_rd),
    .stat   (q_stat)
  );

  sxt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .q_data  (rec_rd),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_data.last_of_run) |=> !empty)
    else $error("second token of a run was not ready after the first transfer");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.token_kind == sxt_pkg::KIND_END) |-> out_data.last_of_run)
    else $error("end token not marked as last of its run");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.token_kind == sxt_pkg::KIND_ERROR) |-> out_data.last_of_run)
    else $error("error token not marked as last of its run");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for s_expression_tokenizer_top: a directed script, then random source text.
// Every token is checked, against the script's own token on a typed row, else against a cycle-free predictor.
// Depends on sxt_pkg and s_expression_tokenizer_top.
module tb_top;

  localparam int RANDOM_ITEMS     = 370;
  localparam int SCRIPT_LEN       = 25;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int HOLD_OFF_CYCLES  = 80;
  localparam int HOLD_OFF_AT      = 40;

  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;
  localparam logic [7:0] CH_LOWER_Q = 8'h71;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;

  localparam sxt_pkg::token_t NO_TOKEN = '0;

  typedef enum logic [2:0] {
    SC_IDLE, SC_COMMENT, SC_HASH, SC_STRING, SC_ESCAPE, SC_NUMBER, SC_IDENT, SC_HALT
  } scan_mode_e;

  typedef struct {
    sxt_pkg::in_item_t item;
    bit                typed;
    sxt_pkg::token_t   tok;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              pop = 1'b0;
  sxt_pkg::in_item_t in_data = '0;
  logic              full;
  logic              empty;
  sxt_pkg::token_t   out_data;

  scan_mode_e  scan;
  logic [23:0] cur_off;
  logic [19:0] cur_line;
  logic [15:0] cur_col;
  logic [23:0] tok_off;
  logic [19:0] tok_line;
  logic [15:0] tok_col;
  logic [31:0] number_acc;

  sxt_pkg::token_t   step_tokens[$];
  sxt_pkg::token_t   tokens_due[$];
  sxt_pkg::in_item_t segment_q[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  tokens_checked = 0;
  int  kind_seen[10];
  int  widest_column = 0;
  int  stall_cycles = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  script_row_t script [SCRIPT_LEN] = '{
    '{'{sxt_pkg::CH_OPEN, 1'b0}, 1'b1,
      '{sxt_pkg::KIND_OPEN, 24'd0, 24'd1, 20'd1, 16'd1, 32'sd0, 1'b1}},
    '{'{sxt_pkg::CH_CLOSE, 1'b0}, 1'b1,
      '{sxt_pkg::KIND_CLOSE, 24'd1, 24'd1, 20'd1, 16'd2, 32'sd0, 1'b1}},
    '{'{sxt_pkg::CH_HASH, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_LOWER_T, 1'b0}, 1'b1,
      '{sxt_pkg::KIND_TRUE, 24'd2, 24'd2, 20'd1, 16'd3, 32'sd0, 1'b1}},
    '{'{8'h00, 1'b1}, 1'b1,
      '{sxt_pkg::KIND_END, 24'd4, 24'd0, 20'd1, 16'd5, 32'sd0, 1'b1}},
    '{'{sxt_pkg::CH_APOSTR, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_HASH, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_LOWER_F, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_NEWLINE, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_SEMICOLON, 1'b0}, 1'b0, NO_TOKEN},
    '{'{CH_LOWER_Z, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_NEWLINE, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_DQUOTE, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_BACKSLASH, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_DQUOTE, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_DQUOTE, 1'b0}, 1'b0, NO_TOKEN},
    '{'{CH_DIGIT9, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_OPEN, 1'b0}, 1'b0, NO_TOKEN},
    '{'{8'hFF, 1'b0}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_CLOSE, 1'b0}, 1'b0, NO_TOKEN},
    '{'{8'h80, 1'b0}, 1'b0, NO_TOKEN},
    '{'{8'h00, 1'b0}, 1'b0, NO_TOKEN},
    '{'{CH_DIGIT0, 1'b0}, 1'b0, NO_TOKEN},
    '{'{8'hFF, 1'b1}, 1'b0, NO_TOKEN},
    '{'{sxt_pkg::CH_SPACE, 1'b0}, 1'b0, NO_TOKEN}
  };

  s_expression_tokenizer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'd0) || (c == sxt_pkg::CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
  endfunction

  function automatic void reset_scanner();
    scan = SC_IDLE;
    cur_off = '0;
    cur_line = 20'd1;
    cur_col = 16'd1;
    tok_off = '0;
    tok_line = 20'd1;
    tok_col = 16'd1;
    number_acc = '0;
  endfunction

  function automatic void move_cursor(logic [7:0] c);
    if (cur_off != '1) cur_off = cur_off + 24'd1;
    if (c == sxt_pkg::CH_NEWLINE) begin
      if (cur_line != '1) cur_line = cur_line + 20'd1;
      cur_col = 16'd1;
    end else if (cur_col != '1) begin
      cur_col = cur_col + 16'd1;
    end
  endfunction

  function automatic void mark_token_start();
    tok_off = cur_off;
    tok_line = cur_line;
    tok_col = cur_col;
  endfunction

  function automatic logic [23:0] token_span();
    return (cur_off >= tok_off) ? cur_off - tok_off : 24'd0;
  endfunction

  function automatic void add_token(logic [3:0] kind, logic [23:0] len, logic [31:0] value);
    sxt_pkg::token_t t;
    t.token_kind   = kind;
    t.start_offset = tok_off;
    t.token_length = len;
    t.start_line   = tok_line;
    t.start_column = tok_col;
    t.number_value = value;
    t.last_of_run  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void scan_between(logic [7:0] c);
    scan = SC_IDLE;
    if (is_blank(c)) begin
      move_cursor(c);
    end else if (c == sxt_pkg::CH_SEMICOLON) begin
      move_cursor(c);
      scan = SC_COMMENT;
    end else if (c == sxt_pkg::CH_APOSTR || c == sxt_pkg::CH_OPEN ||
                 c == sxt_pkg::CH_CLOSE) begin
      mark_token_start();
      move_cursor(c);
      add_token(c == sxt_pkg::CH_APOSTR ? sxt_pkg::KIND_QUOTE :
                (c == sxt_pkg::CH_OPEN ? sxt_pkg::KIND_OPEN : sxt_pkg::KIND_CLOSE),
                token_span(), '0);
    end else if (c == sxt_pkg::CH_HASH) begin
      mark_token_start();
      move_cursor(c);
      scan = SC_HASH;
    end else if (c == sxt_pkg::CH_DQUOTE) begin
      move_cursor(c);
      mark_token_start();
      scan = SC_STRING;
    end else if (is_numeral(c)) begin
      mark_token_start();
      number_acc = {24'd0, c - CH_DIGIT0};
      move_cursor(c);
      scan = SC_NUMBER;
    end else begin
      mark_token_start();
      move_cursor(c);
      scan = SC_IDENT;
    end
  endfunction

  function automatic void flush_partial();
    case (scan)
      SC_STRING, SC_ESCAPE: add_token(sxt_pkg::KIND_STRING, token_span(), '0);
      SC_NUMBER:            add_token(sxt_pkg::KIND_NUMBER, token_span(), number_acc);
      SC_IDENT:             add_token(sxt_pkg::KIND_IDENT, token_span(), '0);
      default: ;
    endcase
  endfunction

  function automatic void tokenize_step(sxt_pkg::in_item_t it);
    logic [7:0] c;
    c = it.source_byte;
    step_tokens.delete();
    if (scan == SC_HALT) return;
    if (it.end_of_input) begin
      if (scan == SC_HASH) begin
        add_token(sxt_pkg::KIND_ERROR, 24'd1, '0);
        scan = SC_HALT;
      end else begin
        flush_partial();
        mark_token_start();
        add_token(sxt_pkg::KIND_END, 24'd0, '0);
        scan = SC_IDLE;
      end
    end else begin
      case (scan)
        SC_COMMENT: begin
          move_cursor(c);
          if (c == sxt_pkg::CH_NEWLINE) scan = SC_IDLE;
        end
        SC_HASH: begin
          if (c == sxt_pkg::CH_LOWER_T || c == sxt_pkg::CH_LOWER_F) begin
            move_cursor(c);
            add_token(c == sxt_pkg::CH_LOWER_T ? sxt_pkg::KIND_TRUE : sxt_pkg::KIND_FALSE,
                      token_span(), '0);
            scan = SC_IDLE;
          end else begin
            add_token(sxt_pkg::KIND_ERROR, 24'd1, '0);
            scan = SC_HALT;
          end
        end
        SC_STRING: begin
          if (c == sxt_pkg::CH_DQUOTE) begin
            add_token(sxt_pkg::KIND_STRING, token_span(), '0);
            move_cursor(c);
            scan = SC_IDLE;
          end else begin
            if (c == sxt_pkg::CH_BACKSLASH) scan = SC_ESCAPE;
            move_cursor(c);
          end
        end
        SC_ESCAPE: begin
          move_cursor(c);
          scan = SC_STRING;
        end
        SC_NUMBER: begin
          if (is_numeral(c)) begin
            number_acc = number_acc * 32'd10 + {24'd0, c - CH_DIGIT0};
            move_cursor(c);
          end else begin
            add_token(sxt_pkg::KIND_NUMBER, token_span(), number_acc);
            scan_between(c);
          end
        end
        SC_IDENT: begin
          if (is_blank(c) || c == sxt_pkg::CH_CLOSE) begin
            add_token(sxt_pkg::KIND_IDENT, token_span(), '0);
            scan_between(c);
          end else begin
            move_cursor(c);
          end
        end
        default: scan_between(c);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic send_item(input sxt_pkg::in_item_t it, input bit typed,
                           input sxt_pkg::token_t typed_tok);
    int gap;
    if (items_sent % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    items_sent++;
    tokenize_step(it);
    if (typed) begin
      tokens_due.push_back(typed_tok);
    end else begin
      foreach (step_tokens[k]) tokens_due.push_back(step_tokens[k]);
    end
  endtask

  function automatic void add_byte(logic [7:0] c);
    sxt_pkg::in_item_t it;
    it.source_byte = c;
    it.end_of_input = 1'b0;
    segment_q.push_back(it);
  endfunction

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(8, 14);
    return (r == 8) ? 8'd0 : ((r == 14) ? sxt_pkg::CH_SPACE : 8'(r));
  endfunction

  function automatic void add_separator();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) add_byte(sxt_pkg::CH_CLOSE);
    else if (r == 1) add_byte(pick_blank());
  endfunction

  // Builds one fragment of source text (a string or comment may be left unterminated), or a stray byte or end marker.
  function automatic void build_segment();
    int pick;
    int len;
    logic [7:0] c;
    sxt_pkg::in_item_t it;
    segment_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      len = $urandom_range(0, 2);
      add_byte(len == 0 ? sxt_pkg::CH_OPEN :
               (len == 1 ? sxt_pkg::CH_CLOSE : sxt_pkg::CH_APOSTR));
    end else if (pick < 20) begin
      add_byte(sxt_pkg::CH_HASH);
      add_byte($urandom_range(0, 1) ? sxt_pkg::CH_LOWER_T : sxt_pkg::CH_LOWER_F);
    end else if (pick < 38) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
      repeat (len) add_byte(CH_DIGIT0 + 8'($urandom_range(0, 9)));
      add_separator();
    end else if (pick < 56) begin
      do c = 8'($urandom_range(0, 255));
      while (is_blank(c) || is_numeral(c) || c == sxt_pkg::CH_SEMICOLON ||
             c == sxt_pkg::CH_APOSTR || c == sxt_pkg::CH_OPEN || c == sxt_pkg::CH_CLOSE ||
             c == sxt_pkg::CH_HASH || c == sxt_pkg::CH_DQUOTE);
      add_byte(c);
      len = $urandom_range(0, 7);
      repeat (len) begin
        do c = 8'($urandom_range(0, 255)); while (is_blank(c) || c == sxt_pkg::CH_CLOSE);
        add_byte(c);
      end
      add_separator();
    end else if (pick < 70) begin
      add_byte(sxt_pkg::CH_DQUOTE);
      len = $urandom_range(0, 8);
      repeat (len) begin
        if ($urandom_range(0, 5) == 0) begin
          add_byte(sxt_pkg::CH_BACKSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end else begin
          do c = 8'($urandom_range(0, 255));
          while (c == sxt_pkg::CH_DQUOTE || c == sxt_pkg::CH_BACKSLASH);
          add_byte(c);
        end
      end
      if ($urandom_range(0, 7) != 0) add_byte(sxt_pkg::CH_DQUOTE);
    end else if (pick < 78) begin
      add_byte(sxt_pkg::CH_SEMICOLON);
      len = $urandom_range(0, 6);
      repeat (len) begin
        do c = 8'($urandom_range(0, 255)); while (c == sxt_pkg::CH_NEWLINE);
        add_byte(c);
      end
      if ($urandom_range(0, 5) != 0) add_byte(sxt_pkg::CH_NEWLINE);
    end else if (pick < 88) begin
      add_byte(pick_blank());
    end else if (pick < 93) begin
      it.source_byte = 8'($urandom_range(0, 255));
      it.end_of_input = 1'b1;
      segment_q.push_back(it);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Run stopped after %0d source items and %0d tokens with no transfer.",
                 items_sent, tokens_checked);
        $display("tb_top failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : result_side
    int gap;
    bit held_off;
    sxt_pkg::token_t want;
    held_off = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (tokens_checked % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 6);
      if (!held_off && tokens_checked == HOLD_OFF_AT) begin
        held_off = 1'b1;
        gap = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (tokens_due.size() == 0) begin
        $error("token of kind %0d arrived with none expected", out_data.token_kind);
        mismatches++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", want.token_kind, out_data.token_kind);
        check_field("start_offset", want.start_offset, out_data.start_offset);
        check_field("token_length", want.token_length, out_data.token_length);
        check_field("start_line", want.start_line, out_data.start_line);
        check_field("start_column", want.start_column, out_data.start_column);
        check_field("number_value", longint'($signed(want.number_value)),
                    longint'($signed(out_data.number_value)));
        check_field("last_of_run", want.last_of_run, out_data.last_of_run);
        if (want.token_kind <= sxt_pkg::KIND_END) kind_seen[want.token_kind]++;
        if (int'(want.start_column) > widest_column) widest_column = int'(want.start_column);
      end
      tokens_checked++;
    end
  end

  initial begin : source_side
    int random_sent;
    sxt_pkg::in_item_t it;
    reset_scanner();
    random_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) send_item(script[i].item, script[i].typed, script[i].tok);

    while (random_sent < RANDOM_ITEMS) begin
      build_segment();
      foreach (segment_q[k]) begin
        it = segment_q[k];
        // A lone hash in random text would halt the scanner, so it is always completed.
        if (scan == SC_HASH && (it.end_of_input ||
            (it.source_byte != sxt_pkg::CH_LOWER_T &&
             it.source_byte != sxt_pkg::CH_LOWER_F))) begin
          it.end_of_input = 1'b0;
          it.source_byte = $urandom_range(0, 1) ? sxt_pkg::CH_LOWER_T : sxt_pkg::CH_LOWER_F;
        end
        send_item(it, 1'b0, NO_TOKEN);
        random_sent++;
      end
    end

    // A malformed hash halts the scanner for good, so it closes the run.
    it.source_byte = sxt_pkg::CH_HASH;
    it.end_of_input = 1'b0;
    send_item(it, 1'b0, NO_TOKEN);
    it.source_byte = CH_LOWER_Q;
    it.end_of_input = 1'($urandom_range(0, 1));
    send_item(it, 1'b0, NO_TOKEN);
    it.source_byte = sxt_pkg::CH_OPEN;
    it.end_of_input = 1'b0;
    send_item(it, 1'b0, NO_TOKEN);
    it.end_of_input = 1'b1;
    send_item(it, 1'b0, NO_TOKEN);
    push <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d source items and checked %0d tokens, %0d of them numbers and %0d strings.",
             items_sent, tokens_checked, kind_seen[sxt_pkg::KIND_NUMBER],
             kind_seen[sxt_pkg::KIND_STRING]);
    $display("Errors seen: %0d; widest start column reached: %0d.",
             kind_seen[sxt_pkg::KIND_ERROR], widest_column);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
